FILE: src/hse_pkg.sv
// Shared types and constants for the heap sort engine.
// No dependencies; imported by every module of the block.
package hse_pkg;

    localparam int WORD_W       = 32;
    localparam int CAPACITY_DEF = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // status of the sort sequencer as seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_sort_status;

endpackage

FILE: src/hse_ram.sv
// Element store: one write port, one read port with registered read data.
// Depends on hse_pkg for the word type.
module hse_ram #(
    parameter int DEPTH = hse_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  hse_pkg::t_word   i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output hse_pkg::t_word   o_rdata
);
    import hse_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/hse_sorter.sv
// Heap sort sequencer: heap build and root extraction over the element store,
// one shared signed comparator, one store read per cycle. Depends on hse_pkg.
module hse_sorter #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CW-1:0]         i_size,
    input  hse_pkg::t_word        i_rdata,
    output logic                  o_we,
    output logic [IW-1:0]         o_waddr,
    output hse_pkg::t_word        o_wdata,
    output logic [IW-1:0]         o_raddr,
    output hse_pkg::t_sort_status o_status
);
    import hse_pkg::*;

    localparam int XW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOADN, S_GETN, S_LEFT, S_RIGHT, S_PICK, S_EXT0, S_EXT1, S_EXT2
    } t_state;

    t_state          r_state;
    logic            r_build;
    logic            r_done;
    logic [IW-1:0]   r_node;
    logic [IW-1:0]   r_big;
    logic [IW-1:0]   r_k;
    logic [IW-1:0]   r_end;
    logic [CW-1:0]   r_hsize;
    t_word           r_nval;
    t_word           r_bigv;

    logic [XW-1:0]   lc;
    logic [XW-1:0]   rc;
    logic            l_ok;
    logic            r_ok;
    t_word           cmp_b;
    logic            cmp_gt;
    logic [IW-1:0]   big1;
    t_word           bigv1;
    logic            moved;
    logic            resolve;
    logic            sift_done;

    assign lc   = XW'({r_node, 1'b1});
    assign rc   = lc + XW'(1);
    assign l_ok = lc < XW'(r_hsize);
    assign r_ok = rc < XW'(r_hsize);

    // the one comparator: left child against the hole value, then right child
    // against the larger of the two
    assign cmp_b  = (r_state == S_RIGHT) ? r_nval : r_bigv;
    assign cmp_gt = i_rdata > cmp_b;

    always_comb begin
        if (r_state == S_RIGHT) begin
            big1  = cmp_gt ? lc[IW-1:0] : r_node;
            bigv1 = cmp_gt ? i_rdata : r_nval;
        end else begin
            big1  = cmp_gt ? rc[IW-1:0] : r_big;
            bigv1 = cmp_gt ? i_rdata : r_bigv;
        end
    end

    assign moved     = big1 != r_node;
    assign resolve   = ((r_state == S_RIGHT) && !r_ok) || (r_state == S_PICK);
    assign sift_done = ((r_state == S_LEFT) && !l_ok) || (resolve && !moved);

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_node;
        o_wdata = r_nval;
        o_raddr = r_node;
        unique case (r_state)
            S_LEFT: begin
                o_raddr = lc[IW-1:0];
                o_we    = !l_ok;
            end
            S_RIGHT: begin
                o_raddr = rc[IW-1:0];
                if (!r_ok) begin
                    o_we    = 1'b1;
                    o_wdata = moved ? bigv1 : r_nval;
                end
            end
            S_PICK: begin
                o_we    = 1'b1;
                o_wdata = moved ? bigv1 : r_nval;
            end
            S_EXT0:  o_raddr = '0;
            S_EXT1:  o_raddr = r_end;
            S_EXT2: begin
                // old root goes to the end of the heap
                o_we    = 1'b1;
                o_waddr = r_end;
                o_wdata = r_bigv;
            end
            default: o_raddr = r_node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_build <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            // done: a set too small to sort, or the last extraction settled
            r_done <= ((r_state == S_IDLE) && i_start && (i_size < CW'(2)))
                   || (sift_done && !r_build && (r_end == IW'(1)));
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && (i_size >= CW'(2))) begin
                        r_hsize <= i_size;
                        r_build <= 1'b1;
                        r_k     <= IW'((i_size >> 1) - CW'(1));
                        r_node  <= IW'((i_size >> 1) - CW'(1));
                        r_state <= S_LOADN;
                    end
                end
                S_LOADN: r_state <= S_GETN;
                S_GETN: begin
                    r_nval  <= i_rdata;
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    if (l_ok) begin
                        r_state <= S_RIGHT;
                    end
                end
                S_RIGHT: begin
                    r_big  <= big1;
                    r_bigv <= bigv1;
                    if (r_ok) begin
                        r_state <= S_PICK;
                    end else if (moved) begin
                        r_node  <= big1;
                        r_state <= S_LEFT;
                    end
                end
                S_PICK: begin
                    if (moved) begin
                        r_node  <= big1;
                        r_state <= S_LEFT;
                    end
                end
                S_EXT0: r_state <= S_EXT1;
                S_EXT1: begin
                    r_bigv  <= i_rdata;
                    r_state <= S_EXT2;
                end
                S_EXT2: begin
                    r_nval  <= i_rdata;
                    r_node  <= '0;
                    r_hsize <= CW'(r_end);
                    r_state <= S_LEFT;
                end
                default: r_state <= S_IDLE;
            endcase

            if (sift_done) begin
                if (r_build) begin
                    if (r_k == '0) begin
                        r_build <= 1'b0;
                        r_end   <= IW'(r_hsize - CW'(1));
                        r_state <= S_EXT0;
                    end else begin
                        r_k     <= r_k - IW'(1);
                        r_node  <= r_k - IW'(1);
                        r_state <= S_LOADN;
                    end
                end else if (r_end == IW'(1)) begin
                    r_state <= S_IDLE;
                end else begin
                    r_end   <= r_end - IW'(1);
                    r_state <= S_EXT0;
                end
            end
        end
    end

    assign o_status.busy = r_state != S_IDLE;
    assign o_status.done = r_done;

endmodule

FILE: src/heap_sort_engine.sv
// Heap sort engine top level: load and drain control, output register.
// Depends on hse_pkg, hse_ram and hse_sorter.
//
// Input channel (i_in_valid / o_in_ready, i_value, i_last): one signed value
// per item. Items up to CAPACITY are stored; further ones are dropped and the
// set is flagged truncated. The item with i_last set closes the set.
// Output channel (o_out_valid / i_out_ready): o_sorted_value in ascending
// order, o_last_out on the final value, o_truncated on every value of a
// truncated set.
// The item with i_last set produces the first result after the sort; every
// following input item (its payload ignored) produces the next result, until
// o_last_out. Then the block loads a new set.
// Loading: one item per cycle. Sort: o_in_ready is low while the sort runs,
// its length set by the single read port of the element store that the sift
// steps share. Drain: an accepted item passes L_FETCH and L_PUT, then its
// result is registered; no new item is taken before that result is put.
// A result waiting on i_out_ready does not block the next input item; the
// block stalls only when a new result is ready and the old one is not taken.
// Reset empties the set and clears the output valid flag; the store is not
// cleared, as only entries written in the current set are read.
module heap_sort_engine #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hse_pkg::t_word i_value,
    input  logic           i_last,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hse_pkg::t_word o_sorted_value,
    output logic           o_last_out,
    output logic           o_truncated
);
    import hse_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        L_LOAD, L_SORT, L_FETCH, L_PUT, L_WAIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [IW-1:0] r_idx;
    logic          r_start;
    logic          r_ovalid;
    t_word         r_odata;
    logic          r_olast;
    logic          r_otrunc;

    logic          in_acc;
    logic          room;
    logic          fin;
    logic          put_go;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_word         mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_word         mem_rdata;

    logic          s_we;
    logic [IW-1:0] s_waddr;
    t_word         s_wdata;
    logic [IW-1:0] s_raddr;
    t_sort_status  s_status;

    assign o_in_ready = (r_state == L_LOAD) || (r_state == L_WAIT);
    assign in_acc     = i_in_valid && o_in_ready;
    assign room       = r_count < CW'(CAPACITY);
    assign fin        = ((CW+1)'(r_idx) + (CW+1)'(1)) >= (CW+1)'(r_count);
    assign put_go     = (r_state == L_PUT) && (!r_ovalid || i_out_ready);

    always_comb begin
        if (r_state == L_SORT) begin
            mem_we    = s_we;
            mem_waddr = s_waddr;
            mem_wdata = s_wdata;
            mem_raddr = s_raddr;
        end else begin
            mem_we    = in_acc && (r_state == L_LOAD) && room;
            mem_waddr = r_count[IW-1:0];
            mem_wdata = i_value;
            mem_raddr = r_idx;
        end
    end

    hse_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hse_sorter #(
        .CAPACITY (CAPACITY)
    ) u_sorter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_size   (r_count),
        .i_rdata  (mem_rdata),
        .o_we     (s_we),
        .o_waddr  (s_waddr),
        .o_wdata  (s_wdata),
        .o_raddr  (s_raddr),
        .o_status (s_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= (r_state == L_LOAD) && in_acc && i_last;
            if (put_go) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                L_LOAD: begin
                    if (in_acc) begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= L_SORT;
                        end
                    end
                end
                L_SORT: begin
                    if (s_status.done) begin
                        r_idx   <= '0;
                        r_state <= L_FETCH;
                    end
                end
                L_FETCH: r_state <= L_PUT;
                L_PUT: begin
                    // read data holds while the address is unchanged
                    if (put_go) begin
                        if (fin) begin
                            r_idx   <= '0;
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= L_LOAD;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= L_WAIT;
                        end
                    end
                end
                L_WAIT: begin
                    if (in_acc) begin
                        r_state <= L_FETCH;
                    end
                end
                default: r_state <= L_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_go) begin
            r_odata  <= mem_rdata;
            r_olast  <= fin;
            r_otrunc <= r_ovf;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sorted_value = r_odata;
    assign o_last_out     = r_olast;
    assign o_truncated    = r_otrunc;

    a_sorter_owns_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_status.busy |-> (r_state == L_SORT))
        else $error("sorter active outside the sort phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_set_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_go && fin) |=> (r_count == '0) && (r_state == L_LOAD) && o_out_valid)
        else $error("final result did not return the block to loading");

    a_done_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_status.done |-> (r_state == L_SORT) && !s_status.busy)
        else $error("sort completion outside the sort phase");

endmodule
